FILE: sv/vector3_fixed_point_alu_top_assert.svh
`ifndef VECTOR3_FIXED_POINT_ALU_TOP_ASSERT_SVH
`define VECTOR3_FIXED_POINT_ALU_TOP_ASSERT_SVH
// Clocked assertion with asynchronous reset disable.
`define V3A_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Implication form.
`define V3A_IMPLIES(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);
`endif

FILE: sv/v3alu_pkg.sv
`default_nettype none
package v3alu_pkg;
	typedef enum logic [3:0] {
		FN_ADD   = 4'd0,
		FN_SUB   = 4'd1,
		FN_SCALE = 4'd2,
		FN_DIV   = 4'd3,
		FN_DOT   = 4'd4,
		FN_CROSS = 4'd5,
		FN_LERP  = 4'd6,
		FN_SQMAG = 4'd7,
		FN_MAG   = 4'd8,
		FN_NORM  = 4'd9
	} func_t;
endpackage
`default_nettype wire

FILE: sv/v3alu_sqrt.sv
`default_nettype none
// Pipelined restoring square root, one result bit per stage.
module v3alu_sqrt #(
	parameter int IN_W  = 128,
	parameter int OUT_W = 64
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [IN_W-1:0]  rad,
	output logic      [OUT_W-1:0] root
);
	logic [IN_W-1:0]  rem_s [OUT_W+1];
	logic [OUT_W-1:0] rt_s  [OUT_W+1];

	assign rem_s[0] = rad;
	assign rt_s[0]  = '0;

	for (genvar g = 0; g < OUT_W; g++) begin : g_bit
		localparam int B = OUT_W - 1 - g;
		logic [IN_W-1:0] trial;
		logic [OUT_W-1:0] cand;
		logic [IN_W-1:0] rem_q;
		logic [OUT_W-1:0] rt_q;
		always_comb begin
			cand  = rt_s[g] | (OUT_W'(1) << B);
			trial = ({{(IN_W-OUT_W){1'b0}}, rt_s[g]} << (B + 1))
				| (IN_W'(1) << (2 * B));
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_s[g] >= trial) begin
					rem_q <= rem_s[g] - trial;
					rt_q  <= cand;
				end else begin
					rem_q <= rem_s[g];
					rt_q  <= rt_s[g];
				end
			end
		end
		assign rem_s[g+1] = rem_q;
		assign rt_s[g+1]  = rt_q;
	end

	assign root = rt_s[OUT_W];
endmodule
`default_nettype wire

FILE: sv/v3alu_div.sv
`default_nettype none
// Pipelined restoring divider, unsigned, one quotient bit per stage.
module v3alu_div #(
	parameter int N_W = 64,
	parameter int D_W = 64
) (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire logic [N_W-1:0] num,
	input  wire logic [D_W-1:0] den,
	output logic      [N_W-1:0] quo
);
	logic [N_W-1:0] n_s [N_W+1];
	logic [D_W:0]   r_s [N_W+1];
	logic [D_W-1:0] d_s [N_W+1];

	assign n_s[0] = num;
	assign r_s[0] = '0;
	assign d_s[0] = den;

	for (genvar g = 0; g < N_W; g++) begin : g_bit
		logic [D_W:0]   sh;
		logic [N_W-1:0] n_q;
		logic [D_W:0]   r_q;
		logic [D_W-1:0] d_q;
		assign sh = {r_s[g][D_W-1:0], n_s[g][N_W-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				d_q <= d_s[g];
				if (sh >= {1'b0, d_s[g]}) begin
					r_q <= sh - {1'b0, d_s[g]};
					n_q <= {n_s[g][N_W-2:0], 1'b1};
				end else begin
					r_q <= sh;
					n_q <= {n_s[g][N_W-2:0], 1'b0};
				end
			end
		end
		assign n_s[g+1] = n_q;
		assign r_s[g+1] = r_q;
		assign d_s[g+1] = d_q;
	end

	assign quo = n_s[N_W];
endmodule
`default_nettype wire

FILE: sv/vector3_fixed_point_alu_top.sv
`default_nettype none
// Streaming three-component Q-format vector ALU. One transfer enters per cycle
// while the output is not stalled, and results leave in order. The pipe is three
// front stages, the square-root pipeline (COMPONENT_WIDTH+1 stages, one root bit
// each), one divisor-select stage, the divider pipeline
// (COMPONENT_WIDTH+FRACTION_BITS+1 stages, one quotient bit each) and the output
// register; every operation travels the full pipe. A stall on the output freezes
// the whole pipe. Divide or normalize by zero returns zero with divide_by_zero
// set; clamped results set saturated.
module vector3_fixed_point_alu_top
	import v3alu_pkg::*;
#(
	parameter int COMPONENT_WIDTH = 32,
	parameter int FRACTION_BITS   = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [3:0]                        func,
	input  wire logic signed [COMPONENT_WIDTH-1:0] a_x,
	input  wire logic signed [COMPONENT_WIDTH-1:0] a_y,
	input  wire logic signed [COMPONENT_WIDTH-1:0] a_z,
	input  wire logic signed [COMPONENT_WIDTH-1:0] b_x,
	input  wire logic signed [COMPONENT_WIDTH-1:0] b_y,
	input  wire logic signed [COMPONENT_WIDTH-1:0] b_z,
	input  wire logic signed [COMPONENT_WIDTH-1:0] scalar_in,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [COMPONENT_WIDTH-1:0]      r_x,
	output logic signed [COMPONENT_WIDTH-1:0]      r_y,
	output logic signed [COMPONENT_WIDTH-1:0]      r_z,
	output logic signed [COMPONENT_WIDTH-1:0]      scalar_out,
	output logic                                   saturated,
	output logic                                   divide_by_zero
);
	`include "vector3_fixed_point_alu_top_assert.svh"

	localparam int W   = COMPONENT_WIDTH;
	localparam int F   = FRACTION_BITS;
	localparam int PW  = 2 * W + 4;
	localparam int SQW = 2 * W + 2;
	localparam int RW  = W + 1;
	localparam int NW  = W + F + 1;
	localparam int SQL = RW;
	localparam int DVL = NW;

	logic en;
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	typedef logic signed [W-1:0] comp_t;
	typedef logic signed [PW-1:0] wide_t;

	function automatic comp_t clamp(input wide_t v, output logic f);
		wide_t hi, lo;
		hi = wide_t'({1'b0, {(W-1){1'b1}}});
		lo = -hi - wide_t'(1);
		f = 1'b0;
		if (v > hi) begin
			f = 1'b1;
			return comp_t'(hi);
		end
		if (v < lo) begin
			f = 1'b1;
			return comp_t'(lo);
		end
		return comp_t'(v);
	endfunction

	// stage 1: operand select, differences
	logic        v_s1;
	logic [3:0]  fn_s1;
	comp_t       a_s1 [3];
	comp_t       b_s1 [3];
	comp_t       s_s1;
	logic signed [W:0] m1_s1 [3];
	logic signed [W:0] m2_s1 [3];
	logic signed [W:0] m3_s1 [3];
	logic signed [W:0] m4_s1 [3];

	comp_t ai [3];
	comp_t bi [3];
	assign ai = '{a_x, a_y, a_z};
	assign bi = '{b_x, b_y, b_z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fn_s1 <= func;
			s_s1  <= scalar_in;
			for (int i = 0; i < 3; i++) begin
				a_s1[i] <= ai[i];
				b_s1[i] <= bi[i];
				case (func)
					FN_CROSS: begin
						m1_s1[i] <= (W+1)'(ai[(i+1)%3]);
						m2_s1[i] <= (W+1)'(bi[(i+2)%3]);
						m3_s1[i] <= (W+1)'(ai[(i+2)%3]);
						m4_s1[i] <= (W+1)'(bi[(i+1)%3]);
					end
					FN_LERP: begin
						m1_s1[i] <= (W+1)'(bi[i]) - (W+1)'(ai[i]);
						m2_s1[i] <= (W+1)'(scalar_in);
						m3_s1[i] <= '0;
						m4_s1[i] <= '0;
					end
					FN_SCALE: begin
						m1_s1[i] <= (W+1)'(ai[i]);
						m2_s1[i] <= (W+1)'(scalar_in);
						m3_s1[i] <= '0;
						m4_s1[i] <= '0;
					end
					FN_DOT: begin
						m1_s1[i] <= (W+1)'(ai[i]);
						m2_s1[i] <= (W+1)'(bi[i]);
						m3_s1[i] <= '0;
						m4_s1[i] <= '0;
					end
					default: begin
						m1_s1[i] <= (W+1)'(ai[i]);
						m2_s1[i] <= (W+1)'(ai[i]);
						m3_s1[i] <= '0;
						m4_s1[i] <= '0;
					end
				endcase
			end
		end
	end

	// stage 2: products
	logic        v_s2;
	logic [3:0]  fn_s2;
	comp_t       a_s2 [3];
	comp_t       b_s2 [3];
	comp_t       s_s2;
	wide_t       p_s2 [3];
	wide_t       q_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fn_s2 <= fn_s1;
			s_s2  <= s_s1;
			for (int i = 0; i < 3; i++) begin
				a_s2[i] <= a_s1[i];
				b_s2[i] <= b_s1[i];
				p_s2[i] <= PW'(m1_s1[i] * m2_s1[i]);
				q_s2[i] <= PW'(m3_s1[i] * m4_s1[i]);
			end
		end
	end

	// stage 3: sums and direct results
	logic        v_s3;
	logic [3:0]  fn_s3;
	comp_t       a_s3 [3];
	comp_t       s_s3;
	comp_t       r_s3 [3];
	comp_t       so_s3;
	logic        sat_s3;
	logic [SQW-1:0] sq_s3;

	comp_t       rc [3];
	comp_t       soc;
	logic        satc;
	wide_t       dsum;

	always_comb begin
		logic f;
		wide_t t;
		satc = 1'b0;
		soc  = '0;
		t    = '0;
		dsum = p_s2[0] + p_s2[1] + p_s2[2];
		for (int i = 0; i < 3; i++) begin
			rc[i] = '0;
			f = 1'b0;
			case (fn_s2)
				FN_ADD: rc[i] = clamp(wide_t'(a_s2[i]) + wide_t'(b_s2[i]), f);
				FN_SUB: rc[i] = clamp(wide_t'(a_s2[i]) - wide_t'(b_s2[i]), f);
				FN_SCALE: rc[i] = clamp(p_s2[i] >>> F, f);
				FN_CROSS: begin
					t = p_s2[i] - q_s2[i];
					rc[i] = clamp(t >>> F, f);
				end
				FN_LERP: rc[i] = clamp(wide_t'(a_s2[i]) + (p_s2[i] >>> F), f);
				default: rc[i] = '0;
			endcase
			satc = satc | f;
		end
		f = 1'b0;
		if (fn_s2 == FN_DOT || fn_s2 == FN_SQMAG) begin
			soc = clamp(dsum >>> F, f);
		end
		satc = satc | f;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fn_s3  <= fn_s2;
			s_s3   <= s_s2;
			a_s3   <= a_s2;
			r_s3   <= rc;
			so_s3  <= soc;
			sat_s3 <= satc;
			sq_s3  <= SQW'(dsum);
		end
	end

	logic [RW-1:0] root;
	v3alu_sqrt #(.IN_W(SQW), .OUT_W(RW)) u_sqrt (
		.clk(clk), .en(en), .rad(sq_s3), .root(root)
	);

	// delay line alongside the root pipe
	typedef struct packed {
		logic        v;
		logic [3:0]  fn;
		logic [W-1:0] ax, ay, az, s, rx, ry, rz, so;
		logic        sat;
	} ctl_t;

	ctl_t d1 [SQL+1];
	assign d1[0] = '{v: v_s3, fn: fn_s3, ax: a_s3[0], ay: a_s3[1], az: a_s3[2],
		s: s_s3, rx: r_s3[0], ry: r_s3[1], rz: r_s3[2], so: so_s3, sat: sat_s3};
	for (genvar g = 0; g < SQL; g++) begin : g_d1
		ctl_t q;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				q <= '0;
			end else if (en) begin
				q <= d1[g];
			end
		end
		assign d1[g+1] = q;
	end

	// stage 4: divisor select and sign split
	ctl_t c_s4;
	logic [RW-1:0] mag_s4;
	logic [RW-1:0] den_s4;
	logic          dz_s4;
	logic          dneg_s4;
	logic [NW-1:0] num_s4 [3];
	logic          nneg_s4 [3];

	ctl_t c3;
	assign c3 = d1[SQL];
	logic [W-1:0] ac [3];
	assign ac = '{c3.ax, c3.ay, c3.az};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s4 <= '0;
		end else if (en) begin
			c_s4 <= c3;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [NW-1:0] n;
		if (en) begin
			mag_s4 <= root;
			if (c3.fn == FN_NORM) begin
				den_s4  <= root;
				dneg_s4 <= 1'b0;
				dz_s4   <= (root == '0);
			end else begin
				den_s4  <= c3.s[W-1] ? RW'(-{c3.s[W-1], c3.s}) : RW'(c3.s);
				dneg_s4 <= c3.s[W-1];
				dz_s4   <= (c3.s == '0);
			end
			for (int i = 0; i < 3; i++) begin
				n = NW'(signed'(ac[i])) <<< F;
				nneg_s4[i] <= n[NW-1];
				num_s4[i]  <= n[NW-1] ? -n : n;
			end
		end
	end

	logic [NW-1:0] qo [3];
	for (genvar k = 0; k < 3; k++) begin : g_div
		v3alu_div #(.N_W(NW), .D_W(RW)) u_div (
			.clk(clk), .en(en), .num(num_s4[k]),
			.den((den_s4 == '0) ? RW'(1) : den_s4), .quo(qo[k])
		);
	end

	typedef struct packed {
		ctl_t          c;
		logic [RW-1:0] mag;
		logic          dz;
		logic          dneg;
		logic [2:0]    nneg;
	} ctl2_t;

	ctl2_t d2 [DVL+1];
	assign d2[0] = '{c: c_s4, mag: mag_s4, dz: dz_s4, dneg: dneg_s4,
		nneg: {nneg_s4[2], nneg_s4[1], nneg_s4[0]}};
	for (genvar g = 0; g < DVL; g++) begin : g_d2
		ctl2_t q;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				q <= '0;
			end else if (en) begin
				q <= d2[g];
			end
		end
		assign d2[g+1] = q;
	end

	// output stage
	ctl2_t e;
	assign e = d2[DVL];

	comp_t ro [3];
	comp_t soo;
	logic  sato;
	logic  dzo;

	always_comb begin
		logic f;
		wide_t qs;
		sato = e.c.sat;
		dzo  = 1'b0;
		ro   = '{comp_t'(e.c.rx), comp_t'(e.c.ry), comp_t'(e.c.rz)};
		soo  = comp_t'(e.c.so);
		case (e.c.fn)
			FN_DIV, FN_NORM: begin
				dzo = e.dz;
				for (int i = 0; i < 3; i++) begin
					f = 1'b0;
					qs = wide_t'({1'b0, qo[i]});
					if (e.nneg[i] ^ e.dneg) begin
						qs = -qs;
					end
					ro[i] = e.dz ? comp_t'(0) : clamp(qs, f);
					sato = sato | f;
				end
			end
			FN_MAG: begin
				f = 1'b0;
				soo = clamp(wide_t'({1'b0, e.mag}), f);
				sato = sato | f;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= e.c.v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_x <= ro[0];
			r_y <= ro[1];
			r_z <= ro[2];
			scalar_out <= soo;
			saturated <= sato;
			divide_by_zero <= dzo;
		end
	end

	`V3A_IMPLIES(a_stall_hold, out_valid && out_stall, in_stall, "stall must freeze the pipe")
	`V3A_IMPLIES(a_dz_zero, out_valid && divide_by_zero,
		r_x == '0 && r_y == '0 && r_z == '0 && !saturated, "divide by zero must give zero")
	`V3A_ASSERT(a_dz_excl, !(out_valid && divide_by_zero && scalar_out != '0),
		"divide flag with scalar result")
endmodule
`default_nettype wire
